/* hdl/msk_pkg.sv */
package msk_pkg;

	// Fixed-point layout
	localparam int COEF_FRAC_BITS = 16;
	localparam int X_FRAC_BITS    = 16;
	localparam int DT_W           = 16;
	localparam int K_W            = 24;
	localparam int X_W            = 17;
	localparam int FLOW_W         = 32;
	localparam int VOL_W          = 64;

	localparam int K2_W   = K_W + 1;
	localparam int KF_W   = K2_W + X_FRAC_BITS;
	localparam int HF_W   = DT_W + X_FRAC_BITS;
	localparam int DEN_W  = KF_W + 1;
	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int DIV_STEPS = COEF_FRAC_BITS + 1;
	localparam int DCNT_W = $clog2(DIV_STEPS);
	localparam int MA_W   = FLOW_W + 1;
	localparam int MB_W   = (COEF_W + 1 > X_W + 1) ? COEF_W + 1 : X_W + 1;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic [X_W-1:0] X_ONE = X_W'(1) << X_FRAC_BITS;

	localparam logic signed [FLOW_W-1:0] FLOW_MAX = {1'b0, {(FLOW_W-1){1'b1}}};
	localparam logic signed [FLOW_W-1:0] FLOW_MIN = {1'b1, {(FLOW_W-1){1'b0}}};
	localparam logic signed [VOL_W-1:0]  VOL_MAX  = {1'b0, {(VOL_W-1){1'b1}}};
	localparam logic signed [VOL_W-1:0]  VOL_MIN  = {1'b1, {(VOL_W-1){1'b0}}};

	// Configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_K    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X    = 2'd2;
	localparam logic [DT_W-1:0] STEP_RESET = 16'd3600;

	// Micro-operations
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD_IN   = 5'd1;
	localparam logic [OP_W-1:0] OP_SETUP     = 5'd2;
	localparam logic [OP_W-1:0] OP_MUL       = 5'd3;
	localparam logic [OP_W-1:0] OP_CLAMP_HI  = 5'd4;
	localparam logic [OP_W-1:0] OP_CLAMP_LO  = 5'd5;
	localparam logic [OP_W-1:0] OP_DEN       = 5'd6;
	localparam logic [OP_W-1:0] OP_DIV_START = 5'd7;
	localparam logic [OP_W-1:0] OP_DIV_ITER  = 5'd8;
	localparam logic [OP_W-1:0] OP_DIV_STORE = 5'd9;
	localparam logic [OP_W-1:0] OP_ACC_SET   = 5'd10;
	localparam logic [OP_W-1:0] OP_ACC_ADD   = 5'd11;
	localparam logic [OP_W-1:0] OP_OUT_SAT   = 5'd12;
	localparam logic [OP_W-1:0] OP_PASS      = 5'd13;
	localparam logic [OP_W-1:0] OP_TRAP      = 5'd14;
	localparam logic [OP_W-1:0] OP_VOL       = 5'd15;
	localparam logic [OP_W-1:0] OP_FINISH    = 5'd16;

	// Operand selects: coefficient for the divider ops, operand pair for OP_MUL
	localparam int SEL_W = 3;
	localparam logic [SEL_W-1:0] SEL_C0      = 3'd0;
	localparam logic [SEL_W-1:0] SEL_C1      = 3'd1;
	localparam logic [SEL_W-1:0] SEL_C2      = 3'd2;
	localparam logic [SEL_W-1:0] MUL_KX      = 3'd0;
	localparam logic [SEL_W-1:0] MUL_C0_IN   = 3'd1;
	localparam logic [SEL_W-1:0] MUL_C1_LIN  = 3'd2;
	localparam logic [SEL_W-1:0] MUL_C2_LOUT = 3'd3;
	localparam logic [SEL_W-1:0] MUL_TRAP    = 3'd4;
	localparam logic [SEL_W-1:0] MUL_VOL     = 3'd5;

	// Branch conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_NEXT       = 3'd0;
	localparam logic [COND_W-1:0] C_GOTO       = 3'd1;
	localparam logic [COND_W-1:0] C_HOLD_NO_IN = 3'd2;
	localparam logic [COND_W-1:0] C_KZERO      = 3'd3;
	localparam logic [COND_W-1:0] C_HOLD_DIV   = 3'd4;
	localparam logic [COND_W-1:0] C_OUT_FREE   = 3'd5;

	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_WAIT = 5'd0;
	localparam logic [PC_W-1:0] PC_PASS = 5'd22;
	localparam logic [PC_W-1:0] PC_TRAP = 5'd23;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SEL_W-1:0]  sel;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} uop_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SEL_W-1:0] sel;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic k_zero;
		logic div_last;
	} seq_stat_t;

	typedef struct packed {
		logic k_zero;
		logic div_last;
	} dp_flags_t;

	function automatic uop_t uop(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
			input logic [COND_W-1:0] cond, input logic [PC_W-1:0] target);
		uop_t u;
		u.op     = op;
		u.sel    = sel;
		u.cond   = cond;
		u.target = target;
		return u;
	endfunction

	function automatic uop_t msk_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			5'd0:  u = uop(OP_LOAD_IN,   SEL_C0,      C_HOLD_NO_IN, PC_WAIT);
			5'd1:  u = uop(OP_SETUP,     SEL_C0,      C_KZERO,      PC_PASS);
			5'd2:  u = uop(OP_MUL,       MUL_KX,      C_NEXT,       PC_WAIT);
			5'd3:  u = uop(OP_CLAMP_HI,  SEL_C0,      C_NEXT,       PC_WAIT);
			5'd4:  u = uop(OP_CLAMP_LO,  SEL_C0,      C_NEXT,       PC_WAIT);
			5'd5:  u = uop(OP_DEN,       SEL_C0,      C_NEXT,       PC_WAIT);
			5'd6:  u = uop(OP_DIV_START, SEL_C0,      C_NEXT,       PC_WAIT);
			5'd7:  u = uop(OP_DIV_ITER,  SEL_C0,      C_HOLD_DIV,   PC_WAIT);
			5'd8:  u = uop(OP_DIV_STORE, SEL_C0,      C_NEXT,       PC_WAIT);
			5'd9:  u = uop(OP_DIV_START, SEL_C1,      C_NEXT,       PC_WAIT);
			5'd10: u = uop(OP_DIV_ITER,  SEL_C1,      C_HOLD_DIV,   PC_WAIT);
			5'd11: u = uop(OP_DIV_STORE, SEL_C1,      C_NEXT,       PC_WAIT);
			5'd12: u = uop(OP_DIV_START, SEL_C2,      C_NEXT,       PC_WAIT);
			5'd13: u = uop(OP_DIV_ITER,  SEL_C2,      C_HOLD_DIV,   PC_WAIT);
			5'd14: u = uop(OP_DIV_STORE, SEL_C2,      C_NEXT,       PC_WAIT);
			5'd15: u = uop(OP_MUL,       MUL_C0_IN,   C_NEXT,       PC_WAIT);
			5'd16: u = uop(OP_ACC_SET,   SEL_C0,      C_NEXT,       PC_WAIT);
			5'd17: u = uop(OP_MUL,       MUL_C1_LIN,  C_NEXT,       PC_WAIT);
			5'd18: u = uop(OP_ACC_ADD,   SEL_C0,      C_NEXT,       PC_WAIT);
			5'd19: u = uop(OP_MUL,       MUL_C2_LOUT, C_NEXT,       PC_WAIT);
			5'd20: u = uop(OP_ACC_ADD,   SEL_C0,      C_NEXT,       PC_WAIT);
			5'd21: u = uop(OP_OUT_SAT,   SEL_C0,      C_GOTO,       PC_TRAP);
			5'd22: u = uop(OP_PASS,      SEL_C0,      C_NEXT,       PC_WAIT);
			5'd23: u = uop(OP_MUL,       MUL_TRAP,    C_NEXT,       PC_WAIT);
			5'd24: u = uop(OP_TRAP,      SEL_C0,      C_NEXT,       PC_WAIT);
			5'd25: u = uop(OP_MUL,       MUL_VOL,     C_NEXT,       PC_WAIT);
			5'd26: u = uop(OP_VOL,       SEL_C0,      C_NEXT,       PC_WAIT);
			5'd27: u = uop(OP_FINISH,    SEL_C0,      C_OUT_FREE,   PC_WAIT);
			default: u = uop(OP_NOP,     SEL_C0,      C_GOTO,       PC_WAIT);
		endcase
		return u;
	endfunction

	function automatic logic signed [VOL_W-1:0] sat_add(input logic signed [VOL_W-1:0] a,
			input logic signed [VOL_W-1:0] b);
		logic [VOL_W:0] s;
		s = {a[VOL_W-1], a} + {b[VOL_W-1], b};
		if (s[VOL_W] != s[VOL_W-1])
			return s[VOL_W] ? VOL_MIN : VOL_MAX;
		return s[VOL_W-1:0];
	endfunction

endpackage

/* hdl/msk_seq.sv */
module msk_seq import msk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output ctrl_t     ctrl,
	output logic      in_open
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	uop_t            uw;
	logic            exec;

	always_comb begin
		uw   = msk_rom(pc_q);
		pc_d = pc_q + 1'b1;
		exec = 1'b1;
		unique case (uw.cond)
			C_NEXT: ;
			C_GOTO: pc_d = uw.target;
			C_HOLD_NO_IN: begin
				exec = stat.in_valid;
				if (!stat.in_valid)
					pc_d = pc_q;
			end
			C_KZERO: begin
				if (stat.k_zero)
					pc_d = uw.target;
			end
			C_HOLD_DIV: begin
				if (!stat.div_last)
					pc_d = pc_q;
			end
			C_OUT_FREE: begin
				exec = stat.out_free;
				pc_d = stat.out_free ? uw.target : pc_q;
			end
			default: pc_d = PC_WAIT;
		endcase
		// the input and output waiting steps only fire their op once the condition is met;
		ctrl.op  = exec ? uw.op : OP_NOP;
		ctrl.sel = uw.sel;
		in_open  = (uw.cond == C_HOLD_NO_IN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

/* hdl/msk_dp.sv */
module msk_dp import msk_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	input  logic [DT_W-1:0]          step_seconds,
	input  logic [K_W-1:0]           storage_constant,
	input  logic [X_W-1:0]           weighting_factor,
	input  logic signed [FLOW_W-1:0] inflow_sample,
	output dp_flags_t                flags,
	output logic signed [FLOW_W-1:0] res_outflow,
	output logic signed [VOL_W-1:0]  res_total,
	output logic signed [VOL_W-1:0]  res_volume
);

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

	logic signed [FLOW_W-1:0] inflow_q, outflow_q, last_in_q, last_out_q;
	logic signed [VOL_W-1:0]  tot_q, vol_q;
	logic [K2_W-1:0]          k2_q;
	logic [X_W-1:0]           x_q;
	logic [DEN_W-1:0]         a_q, den_q;
	logic [DEN_W:0]           rem_q;
	logic [COEF_W-1:0]        quo_q, c0_q, c1_q, c2_q;
	logic [DCNT_W-1:0]        cnt_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;

	logic [KF_W-1:0]          kf;
	logic [HF_W-1:0]          hf;
	logic [DEN_W:0]           kf_w, hf_w, a_w, apf, den_w, num, rem_sh;
	logic                     rem_ge;
	logic [K2_W-1:0]          k2_raw, dt_ext;
	logic [COEF_W:0]          quo_inc;
	logic [COEF_W-1:0]        coef_new;
	logic signed [MA_W-1:0]   ma;
	logic signed [MB_W-1:0]   mb;
	logic signed [SUM_W-1:0]  sh;
	logic                     sat_hi, sat_lo;
	logic signed [PROD_W-1:0] half_prod;

	always_comb begin
		kf     = {k2_q, {X_FRAC_BITS{1'b0}}};
		hf     = {step_seconds, {X_FRAC_BITS{1'b0}}};
		kf_w   = (DEN_W+1)'(kf);
		hf_w   = (DEN_W+1)'(hf);
		a_w    = (DEN_W+1)'(a_q);
		apf    = a_w + hf_w;
		den_w  = (DEN_W+1)'(den_q);
		rem_sh = {rem_q[DEN_W-1:0], 1'b0};
		rem_ge = (rem_sh >= den_w);
		k2_raw = {storage_constant, 1'b0};
		dt_ext = K2_W'(step_seconds);

		unique case (ctrl.sel)
			SEL_C0:  num = (hf_w > a_w) ? hf_w - a_w : '0;
			SEL_C1:  num = apf;
			SEL_C2:  num = (kf_w > apf) ? kf_w - apf : '0;
			default: num = '0;
		endcase

		// round half up: (q + 1) >> 1
		quo_inc  = (COEF_W+1)'(quo_q) + (COEF_W+1)'(1);
		coef_new = quo_inc[COEF_W:1];

		unique case (ctrl.sel)
			MUL_KX: begin
				ma = MA_W'(k2_q);
				mb = MB_W'(x_q);
			end
			MUL_C0_IN: begin
				ma = MA_W'(inflow_q);
				mb = MB_W'(c0_q);
			end
			MUL_C1_LIN: begin
				ma = MA_W'(last_in_q);
				mb = MB_W'(c1_q);
			end
			MUL_C2_LOUT: begin
				ma = MA_W'(last_out_q);
				mb = MB_W'(c2_q);
			end
			MUL_TRAP: begin
				ma = MA_W'(outflow_q) + MA_W'(last_out_q);
				mb = MB_W'(step_seconds);
			end
			MUL_VOL: begin
				ma = MA_W'(inflow_q) - MA_W'(outflow_q);
				mb = MB_W'(step_seconds);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase

		sh        = sum_q >>> COEF_FRAC_BITS;
		sat_hi    = !sh[SUM_W-1] && (|sh[SUM_W-2:FLOW_W-1]);
		sat_lo    = sh[SUM_W-1] && !(&sh[SUM_W-2:FLOW_W-1]);
		half_prod = prod_q >>> 1;

		flags.k_zero   = (storage_constant == '0);
		flags.div_last = (cnt_q == DCNT_W'(COEF_FRAC_BITS));
	end

	// routing state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_in_q  <= '0;
			last_out_q <= '0;
			tot_q      <= '0;
			vol_q      <= '0;
		end else begin
			unique case (ctrl.op)
				OP_TRAP:   tot_q <= sat_add(tot_q, VOL_W'(half_prod));
				OP_VOL:    vol_q <= sat_add(vol_q, VOL_W'(prod_q));
				OP_FINISH: begin
					last_in_q  <= inflow_q;
					last_out_q <= outflow_q;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD_IN: inflow_q <= inflow_sample;
			OP_SETUP: begin
				k2_q <= (k2_raw < dt_ext) ? dt_ext : k2_raw;
				x_q  <= (weighting_factor > X_ONE) ? X_ONE : weighting_factor;
			end
			OP_MUL: prod_q <= ma * mb;
			OP_CLAMP_HI: begin
				a_q <= (prod_q[DEN_W-1:0] >= DEN_W'(hf)) ? DEN_W'(hf) : prod_q[DEN_W-1:0];
			end
			OP_CLAMP_LO: begin
				if (kf_w - a_w <= hf_w)
					a_q <= DEN_W'(kf_w - hf_w);
			end
			OP_DEN: den_q <= DEN_W'(kf_w - a_w + hf_w);
			OP_DIV_START: begin
				cnt_q <= '0;
				if (num >= den_w) begin
					rem_q <= '0;
					quo_q <= COEF_W'(1);
				end else begin
					rem_q <= num;
					quo_q <= '0;
				end
			end
			OP_DIV_ITER: begin
				rem_q <= rem_ge ? rem_sh - den_w : rem_sh;
				quo_q <= {quo_q[COEF_W-2:0], rem_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_DIV_STORE: begin
				unique case (ctrl.sel)
					SEL_C0:  c0_q <= coef_new;
					SEL_C1:  c1_q <= coef_new;
					default: c2_q <= coef_new;
				endcase
			end
			OP_ACC_SET: sum_q <= SUM_W'(prod_q) + ROUND_HALF;
			OP_ACC_ADD: sum_q <= sum_q + SUM_W'(prod_q);
			OP_OUT_SAT: outflow_q <= sat_hi ? FLOW_MAX : (sat_lo ? FLOW_MIN : sh[FLOW_W-1:0]);
			OP_PASS:    outflow_q <= inflow_q;
			OP_FINISH: begin
				res_outflow <= outflow_q;
				res_total   <= tot_q;
				res_volume  <= vol_q;
			end
			default: ;
		endcase
	end

endmodule

/* hdl/muskingum_routing_step.sv */
// Muskingum routing of one river reach, one inflow sample per time step.
// Input channel: in_valid / in_stall carrying inflow_sample (Q16.16).
// Output channel: out_valid / out_stall carrying outflow_sample (Q16.16),
// total_outflow and stored_volume (both Q48.16, saturating sums).
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// step_seconds (0), storage_constant (1) or weighting_factor (2); write
// only while no sample is in flight.
// A microcoded sequencer steps a shared multiplier and a one-bit-per-cycle
// restoring divider. With a non-zero storage constant the run of a sample is
// set mostly by the three coefficient divisions; with storage constant zero
// the sequencer skips them and takes the outflow equal to the inflow.
// The result beat is offered on the cycle after the last step; the next
// sample can be accepted in that same cycle.
// A finished result waits in the output register while the next sample is
// worked on; if it is still stalled when the next result is ready, the
// sequencer holds until it is taken.
// Reset returns step_seconds to 3600, the other registers, the previous
// inflow and outflow and both sums to zero.
module muskingum_routing_step import msk_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [FLOW_W-1:0] inflow_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [FLOW_W-1:0] outflow_sample,
	output logic signed [VOL_W-1:0]  total_outflow,
	output logic signed [VOL_W-1:0]  stored_volume
);

	logic [DT_W-1:0] step_q;
	logic [K_W-1:0]  k_q;
	logic [X_W-1:0]  x_q;
	logic            out_valid_q;
	logic            out_free;
	logic            in_open;
	logic            fin;
	ctrl_t           ctrl;
	seq_stat_t       seq_stat;
	dp_flags_t       flags;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			k_q    <= '0;
			x_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STEP: step_q <= cfg_data[DT_W-1:0];
				CFG_K:    k_q    <= cfg_data[K_W-1:0];
				CFG_X:    x_q    <= cfg_data[X_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign fin      = (ctrl.op == OP_FINISH);

	always_comb begin
		seq_stat.in_valid = in_valid;
		seq_stat.out_free = out_free;
		seq_stat.k_zero   = flags.k_zero;
		seq_stat.div_last = flags.div_last;
	end

	msk_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.stat    (seq_stat),
		.ctrl    (ctrl),
		.in_open (in_open)
	);

	msk_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.step_seconds     (step_q),
		.storage_constant (k_q),
		.weighting_factor (x_q),
		.inflow_sample    (inflow_sample),
		.flags            (flags),
		.res_outflow      (outflow_sample),
		.res_total        (total_outflow),
		.res_volume       (stored_volume)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = !in_open;

	// the input is stalled in the cycle after a beat is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken on consecutive cycles");

	// a new result never overwrites one still held by the receiver
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> out_valid)
		else $error("finished result not offered");

endmodule
